FILE: design/lzwd_pkg.sv
// Shared constants, types and state encoding for the LZSS window decoder.
`default_nettype none

package lzwd_pkg;

    // WINDOW_SIZE must be a power of two: window addresses wrap by truncation.
    localparam int WINDOW_SIZE     = 4096;
    localparam int LOOKAHEAD       = 18;
    localparam int MATCH_THRESHOLD = 2;
    localparam int MAX_RESULTS     = 18;

    localparam int ADDR_W = $clog2(WINDOW_SIZE);
    localparam int LEN_W  = $clog2(MAX_RESULTS);

    localparam logic [7:0]        FILL_BYTE = 8'h20;
    localparam logic [ADDR_W-1:0] WP_RESET  = ADDR_W'(WINDOW_SIZE - LOOKAHEAD);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(WINDOW_SIZE - 1);

    localparam logic [15:0] FLAG_FILL = 16'hff00;

    localparam logic [1:0] PH_FLAG  = 2'd0;  // expect flag byte
    localparam logic [1:0] PH_TOKEN = 2'd1;  // literal or match low byte
    localparam logic [1:0] PH_HIGH  = 2'd2;  // match high byte

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              clear_start;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
    } win_req_t;

endpackage

`default_nettype wire

FILE: design/lzss_window_decoder_core.sv
// Top level of the LZSS decoder: token sequencer, copy engine and output register.
`default_nettype none

// LZSS decoder with a 4096-byte history window. Compressed bytes enter one
// item at a time on the s_axis side; stream_start on tuser reinitializes the
// window, write position and flags before that byte is decoded. After reset
// and after every stream_start the window is filled with spaces by a sweep
// over every window address during which no item is taken. A flag byte or a
// match low byte passes through ST_DECODE; a literal is written to the window
// and then offered in ST_OUT; a match copies its bytes one at a time through
// ST_READ, ST_WRITE and ST_OUT: each copied byte needs a registered read, a
// write-back and an output handshake before the next read. The sequencer
// holds s_axis_tready low while an item is in work and waits on m_axis_tready;
// m_axis_tlast marks the last byte produced by an input item.
module lzss_window_decoder_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tuser,   // [0] stream_start
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast    // last_of_run
);
    import lzwd_pkg::*;

    state_t            state_reg, state_next;
    logic              pend_reg, pend_next;
    logic [7:0]        byte_reg, byte_next;
    logic [1:0]        phase_reg, phase_next;
    logic [15:0]       flag_reg, flag_next;
    logic [7:0]        low_reg, low_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [ADDR_W-1:0] rpos_reg, rpos_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]        odata_reg, odata_next;
    logic              olast_reg, olast_next;

    win_req_t   win_req;
    logic [7:0] rd_data;
    logic       clear_busy;
    logic [15:0] flag_shifted;
    logic [5:0]  match_len;
    logic [11:0] match_pos;

    lzwd_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (win_req),
        .rd_addr    (rpos_reg),
        .rd_data    (rd_data),
        .clear_busy (clear_busy)
    );

    assign flag_shifted = flag_reg >> 1;
    assign match_pos    = {byte_reg[7:4], low_reg};

    always_comb
    begin
        match_len = 6'(byte_reg[3:0]) + 6'(MATCH_THRESHOLD + 1);
        if (match_len > 6'(MAX_RESULTS))
        begin
            match_len = 6'(MAX_RESULTS);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        byte_next  = byte_reg;
        phase_next = phase_reg;
        flag_next  = flag_reg;
        low_next   = low_reg;
        wp_next    = wp_reg;
        rpos_next  = rpos_reg;
        cnt_next   = cnt_reg;
        odata_next = odata_reg;
        olast_next = olast_reg;

        win_req.clear_start = 1'b0;
        win_req.wr_en       = 1'b0;
        win_req.wr_addr     = wp_reg;
        win_req.wr_data     = byte_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                if (!clear_busy)
                begin
                    state_next = pend_reg ? ST_DECODE : ST_IDLE;
                    pend_next  = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    byte_next = s_axis_tdata;
                    if (s_axis_tuser)
                    begin
                        phase_next          = PH_FLAG;
                        flag_next           = '0;
                        low_next            = '0;
                        wp_next             = WP_RESET;
                        pend_next           = 1'b1;
                        win_req.clear_start = 1'b1;
                        state_next          = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_DECODE;
                    end
                end
            end
            ST_DECODE:
            begin
                case (phase_reg)
                    PH_TOKEN:
                    begin
                        if (flag_reg[0])
                        begin
                            win_req.wr_en = 1'b1;
                            wp_next       = wp_reg + 1'b1;
                            odata_next    = byte_reg;
                            olast_next    = 1'b1;
                            flag_next     = flag_shifted;
                            phase_next    = flag_shifted[8] ? PH_TOKEN : PH_FLAG;
                            state_next    = ST_OUT;
                        end
                        else
                        begin
                            low_next   = byte_reg;
                            phase_next = PH_HIGH;
                            state_next = ST_IDLE;
                        end
                    end
                    PH_HIGH:
                    begin
                        rpos_next  = match_pos[ADDR_W-1:0];
                        cnt_next   = LEN_W'(match_len - 6'd1);
                        state_next = ST_READ;
                    end
                    default:
                    begin
                        // flag byte; the unused phase behaves the same way
                        flag_next  = {8'h00, byte_reg} | FLAG_FILL;
                        phase_next = PH_TOKEN;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                win_req.wr_en   = 1'b1;
                win_req.wr_data = rd_data;
                wp_next         = wp_reg + 1'b1;
                rpos_next       = rpos_reg + 1'b1;
                odata_next      = rd_data;
                olast_next      = (cnt_reg == '0);
                if (cnt_reg == '0)
                begin
                    flag_next  = flag_shifted;
                    phase_next = flag_shifted[8] ? PH_TOKEN : PH_FLAG;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    if (olast_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            pend_reg  <= 1'b0;
            phase_reg <= PH_FLAG;
            flag_reg  <= '0;
            low_reg   <= '0;
            wp_reg    <= WP_RESET;
            cnt_reg   <= '0;
            olast_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            phase_reg <= phase_next;
            flag_reg  <= flag_next;
            low_reg   <= low_next;
            wp_reg    <= wp_next;
            cnt_reg   <= cnt_next;
            olast_reg <= olast_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        rpos_reg  <= rpos_next;
        odata_reg <= odata_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = olast_reg;

endmodule

`default_nettype wire

FILE: design/lzwd_window.sv
// History window memory with its fill-with-spaces sweep.
`default_nettype none

module lzwd_window (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire lzwd_pkg::win_req_t        req,
    input  wire logic [lzwd_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                     rd_data,
    output logic                           clear_busy
);
    import lzwd_pkg::*;

    logic [7:0]        mem [WINDOW_SIZE];
    logic              busy_reg;
    logic              busy_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [7:0]        rd_data_reg;

    always_comb
    begin
        busy_next     = busy_reg;
        clr_addr_next = clr_addr_reg;
        if (req.clear_start)
        begin
            busy_next     = 1'b1;
            clr_addr_next = '0;
        end
        else if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_LAST)
            begin
                busy_next = 1'b0;
            end
        end
        we    = busy_reg ? 1'b1 : req.wr_en;
        waddr = busy_reg ? clr_addr_reg : req.wr_addr;
        wdata = busy_reg ? FILL_BYTE : req.wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = busy_reg;

endmodule

`default_nettype wire

FILE: bench/lzss_window_decoder_core_tb.sv
// Self-checking testbench for the LZSS window decoder core against a shadow decoder.
module lzss_window_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lzwd_pkg::*;

    localparam int STALL_LIMIT = 5 * WINDOW_SIZE;  // clear sweep plus generous slack
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 4 * MAX_RESULTS;
    localparam int PHASE_ITEMS = 120;

    typedef struct {
        logic       start;
        logic [7:0] data;
        bit         drain_first;  // sender waits until every output byte has come
    } comp_byte_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } plain_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tuser = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    comp_byte_t  comp_bytes[$];
    plain_byte_t plain_bytes[$];

    // shadow decoder state
    logic [7:0]        hist_mem[WINDOW_SIZE];
    logic [ADDR_W-1:0] hist_wpos;
    logic [15:0]       flag_bits;
    logic [1:0]        tok_phase;
    logic [7:0]        ofs_low;

    // stream generator state
    logic [ADDR_W-1:0] gen_wpos;
    bit                gen_need_start = 1'b1;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_done = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int fail_count = 0;
    int n_in = 0;
    int n_out = 0;
    int n_literals = 0;
    int n_matches = 0;
    int n_starts = 0;

    lzss_window_decoder_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(string msg);
        fail_count++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function automatic void clear_history();
        foreach (hist_mem[i])
            hist_mem[i] = FILL_BYTE;
        hist_wpos = WP_RESET;
        flag_bits = '0;
        tok_phase = PH_FLAG;
        ofs_low   = '0;
    endfunction

    function automatic void emit_plain(logic [7:0] b, logic last);
        hist_mem[hist_wpos] = b;
        hist_wpos++;
        plain_bytes.push_back('{b, last});
    endfunction

    function automatic void next_flag();
        flag_bits = flag_bits >> 1;
        tok_phase = flag_bits[8] ? PH_TOKEN : PH_FLAG;
    endfunction

    // Advances the shadow decoder by one compressed item.
    function automatic void decode_byte(logic start, logic [7:0] data);
        logic [ADDR_W-1:0] src;
        int                len;
        if (start)
        begin
            clear_history();
            n_starts++;
        end
        case (tok_phase)
            PH_TOKEN:
            begin
                if (flag_bits[0])
                begin
                    emit_plain(data, 1'b1);
                    n_literals++;
                    next_flag();
                end
                else
                begin
                    ofs_low   = data;
                    tok_phase = PH_HIGH;
                end
            end
            PH_HIGH:
            begin
                src = ADDR_W'({data[7:4], ofs_low});
                len = int'(data[3:0]) + MATCH_THRESHOLD + 1;
                if (len > MAX_RESULTS)
                    len = MAX_RESULTS;
                // byte by byte, so an overlapping copy sees what it just wrote
                for (int k = 0; k < len; k++)
                begin
                    emit_plain(hist_mem[src], k == len - 1);
                    src++;
                end
                n_matches++;
                next_flag();
            end
            default:
            begin
                flag_bits = FLAG_FILL | {8'h00, data};
                tok_phase = PH_TOKEN;
            end
        endcase
    endfunction

    function automatic void queue_byte(logic start, logic [7:0] data, bit drain);
        comp_bytes.push_back('{start, data, drain});
    endfunction

    // One flag byte and its tokens; now and then cut short, then the next group restarts.
    function automatic int gen_group(bit drain);
        logic [7:0]        flags;
        logic [ADDR_W-1:0] pos;
        int                ntok;
        int                nib;
        int                cnt;
        bit                cut;
        bit                start;
        start = gen_need_start || ($urandom_range(24) == 0);
        if (start)
            gen_wpos = WP_RESET;
        flags = 8'($urandom);
        cut   = ($urandom_range(9) == 0);
        ntok  = cut ? $urandom_range(7) : 8;
        gen_need_start = cut;
        queue_byte(start, flags, drain);
        cnt = 1;
        for (int t = 0; t < ntok; t++)
        begin
            if (flags[t])
            begin
                queue_byte(1'b0, 8'($urandom), 1'b0);
                gen_wpos++;
                cnt++;
            end
            else
            begin
                if ($urandom_range(9) < 7)
                    pos = gen_wpos - ADDR_W'($urandom_range(1, 24));
                else
                    pos = ADDR_W'($urandom);
                nib = $urandom_range(15);
                queue_byte(1'b0, pos[7:0], 1'b0);
                queue_byte(1'b0, {pos[11:8], 4'(nib)}, 1'b0);
                gen_wpos += ADDR_W'(nib + MATCH_THRESHOLD + 1);
                cnt += 2;
            end
        end
        if (cut)
        begin
            // dangling byte: literal or an unfinished match, depending on the flag
            queue_byte(1'b0, 8'($urandom), 1'b0);
            cnt++;
        end
        return cnt;
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        comp_byte_t nxt;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_byte(s_axis_tuser, s_axis_tdata);
                n_in++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (comp_bytes.size() > 0
                    && !(comp_bytes[0].drain_first && plain_bytes.size() != 0)
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = comp_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.data;
                    s_axis_tuser  <= nxt.start;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin : monitor_proc
        plain_byte_t exp_b;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (plain_bytes.size() == 0)
                    report_mismatch($sformatf("unexpected output byte %02h last %0b",
                                              m_axis_tdata, m_axis_tlast));
                else
                begin
                    exp_b = plain_bytes.pop_front();
                    n_out++;
                    if (m_axis_tdata !== exp_b.data)
                        report_mismatch($sformatf("out_byte %02h, expected %02h (byte %0d)",
                                                  m_axis_tdata, exp_b.data, n_out));
                    if (m_axis_tlast !== exp_b.last)
                        report_mismatch($sformatf("last_of_run %0b, expected %0b (byte %0d)",
                                                  m_axis_tlast, exp_b.last, n_out));
                end
            end
            if (holds_done != hold_requests)
            begin
                hold_left     <= LONG_HOLD;
                holds_done    <= holds_done + 1;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog: cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles, %0d output bytes outstanding",
                     idle_cycles, plain_bytes.size());
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic wait_sent();
        while (comp_bytes.size() != 0 || s_axis_tvalid)
            @(posedge clk);
    endtask

    initial
    begin : stim_proc
        int cnt;
        clear_history();

        // directed: all token kinds, window wrap, full-length and overlapping copies
        queue_byte(1'b1, 8'h55, 1'b0);  // lit, match, lit, match, ...
        queue_byte(1'b0, 8'h00, 1'b0);
        queue_byte(1'b0, 8'hff, 1'b0);  // top of window, longest copy, wraps
        queue_byte(1'b0, 8'hff, 1'b0);
        queue_byte(1'b0, 8'hff, 1'b0);
        queue_byte(1'b0, 8'h01, 1'b0);  // one behind write position: overlapping run
        queue_byte(1'b0, 8'h00, 1'b0);
        queue_byte(1'b0, 8'h80, 1'b0);
        queue_byte(1'b0, 8'h00, 1'b0);  // position zero, shortest copy
        queue_byte(1'b0, 8'h00, 1'b0);
        queue_byte(1'b0, 8'h7f, 1'b0);
        queue_byte(1'b0, 8'ha5, 1'b0);
        queue_byte(1'b0, 8'h5a, 1'b0);
        queue_byte(1'b0, 8'hff, 1'b0);  // eight literals
        for (int i = 0; i < 8; i++)
            queue_byte(1'b0, 8'(8'h01 << i), 1'b0);
        queue_byte(1'b0, 8'h00, 1'b0);  // all matches, left unfinished by a restart
        queue_byte(1'b0, 8'h34, 1'b0);

        send_idle_pct = 36;
        recv_idle_pct = 45;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        cnt = 0;
        while (cnt < PHASE_ITEMS)
            cnt += gen_group(1'b0);
        wait_sent();

        send_idle_pct = 45;
        recv_idle_pct = 36;
        cnt = gen_group(1'b1);
        while (cnt < PHASE_ITEMS)
            cnt += gen_group($urandom_range(39) == 0);
        wait_sent();

        // no idling; a long receiver hold first so the input backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests = hold_requests + 1;
        cnt = 0;
        while (cnt < PHASE_ITEMS)
            cnt += gen_group(1'b0);
        wait_sent();

        while (plain_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Decoded %0d compressed bytes (%0d literals, %0d matches, %0d stream starts)",
                 n_in, n_literals, n_matches, n_starts);
        $display("Checked %0d output bytes under sender/receiver stalls, %0d mismatches",
                 n_out, fail_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
